@@ rtl/ttrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttrc_pkg
// Shared types, constants and arithmetic helpers for the three-term
// recurrence checksum unit.
// ----------------------------------------------------------------------------
package ttrc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TERM_W  = 16;
	localparam int unsigned PROD_W  = TERM_W + BYTE_W + 1;

	localparam logic [TERM_W-1:0] FOLD_MOD     = 16'hFFFF;
	localparam logic [TERM_W-1:0] TERM_ONE     = 16'd1;
	localparam logic [BYTE_W-1:0] FIRST_OFFSET = 8'd7;
	localparam logic [BYTE_W-1:0] POS_FIRST    = 8'd1;
	localparam logic [BYTE_W-1:0] POS_RESET    = 8'd0;

	// One byte item as it moves from the input register to the recurrence stage.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} byte_item_t;

	// 17*i mod 256.
	function automatic logic [BYTE_W-1:0] alpha_of(input logic [BYTE_W-1:0] pos);
		logic [BYTE_W-1:0] shifted;
		shifted = {pos[BYTE_W-5:0], 4'b0000};
		return pos + shifted;
	endfunction

	// 31*i mod 256.
	function automatic logic [BYTE_W-1:0] beta_of(input logic [BYTE_W-1:0] pos);
		logic [BYTE_W-1:0] shifted;
		shifted = {pos[BYTE_W-6:0], 5'b00000};
		return shifted - pos;
	endfunction

	// Value modulo 65535. Since 2^16 is 1 modulo 65535, the upper bits fold
	// onto the lower half twice; a final compare removes a result of 65535.
	function automatic logic [TERM_W-1:0] mod_fold(input logic [PROD_W-1:0] x);
		logic [TERM_W:0]   first;
		logic [TERM_W:0]   second;
		logic [TERM_W-1:0] folded;
		first  = {1'b0, x[TERM_W-1:0]} + {{(2*TERM_W-PROD_W+1){1'b0}}, x[PROD_W-1:TERM_W]};
		second = {1'b0, first[TERM_W-1:0]} + {{TERM_W{1'b0}}, first[TERM_W]};
		folded = second[TERM_W-1:0];
		return (folded == FOLD_MOD) ? '0 : folded;
	endfunction

endpackage

@@ rtl/ttrc_in_reg.sv @@
// ----------------------------------------------------------------------------
// ttrc_in_reg
// Input register for the byte channel. Holds one item until the recurrence
// stage takes it, and loads a new one in the same cycle.
// ----------------------------------------------------------------------------
module ttrc_in_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [ttrc_pkg::BYTE_W-1:0] data_byte,
	input  logic                        last_byte,
	input  logic                        take,
	output ttrc_pkg::byte_item_t        item_s1
);
	import ttrc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;
	logic              load;

	assign byte_stall = valid_s1 && !take;
	assign load       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || take) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign item_s1 = '{valid: valid_s1, data_byte: data_s1, last_byte: last_s1};

endmodule

@@ rtl/ttrc_recur.sv @@
// ----------------------------------------------------------------------------
// ttrc_recur
// Recurrence stage: holds the two terms and the byte position, forms the next
// term from the registered byte, and registers the checksum of each message.
// ----------------------------------------------------------------------------
module ttrc_recur (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ttrc_pkg::byte_item_t        item_s1,
	output logic                        take,
	output logic                        sum_valid,
	input  logic                        sum_stall,
	output logic [ttrc_pkg::TERM_W-1:0] checksum
);
	import ttrc_pkg::*;

	logic [TERM_W-1:0] older_q;
	logic [TERM_W-1:0] newer_q;
	logic [BYTE_W-1:0] pos_q;
	logic              in_msg_q;
	logic              sum_valid_q;
	logic [TERM_W-1:0] checksum_q;

	logic              out_free;
	logic [BYTE_W:0]   coef_a;
	logic [BYTE_W-1:0] coef_b;
	logic [PROD_W-1:0] prod_a;
	logic [PROD_W-1:0] prod_b;
	logic              negative;
	logic [PROD_W-1:0] magnitude;
	logic [TERM_W-1:0] mag_mod;
	logic [TERM_W-1:0] next_term;
	logic [TERM_W-1:0] term_out;

	assign out_free = !sum_valid_q || !sum_stall;
	// A non-final byte never needs the output register, so it moves on freely.
	assign take     = item_s1.valid && (!item_s1.last_byte || out_free);

	assign coef_a = {1'b0, item_s1.data_byte} + {1'b0, alpha_of(pos_q)};
	assign coef_b = beta_of(pos_q);
	assign prod_a = {{(PROD_W-BYTE_W-1){1'b0}}, coef_a}
		* {{(PROD_W-TERM_W){1'b0}}, newer_q};
	assign prod_b = {{(PROD_W-BYTE_W){1'b0}}, coef_b}
		* {{(PROD_W-TERM_W){1'b0}}, older_q};

	assign negative  = prod_a < prod_b;
	assign magnitude = negative ? (prod_b - prod_a) : (prod_a - prod_b);
	assign mag_mod   = mod_fold(magnitude);

	// A negative difference of magnitude k wraps in 64 bits to (1 - k) mod 65535.
	always_comb begin
		if (!negative) begin
			next_term = mag_mod;
		end else if (mag_mod <= TERM_ONE) begin
			next_term = TERM_ONE - mag_mod;
		end else begin
			next_term = FOLD_MOD - mag_mod + TERM_ONE;
		end
	end

	assign term_out = in_msg_q ? next_term
		: ({{(TERM_W-BYTE_W){1'b0}}, item_s1.data_byte}
			+ {{(TERM_W-BYTE_W){1'b0}}, FIRST_OFFSET});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= TERM_ONE;
			newer_q  <= TERM_ONE;
			pos_q    <= POS_RESET;
			in_msg_q <= 1'b0;
		end else if (take) begin
			if (item_s1.last_byte) begin
				older_q  <= TERM_ONE;
				newer_q  <= TERM_ONE;
				pos_q    <= POS_RESET;
				in_msg_q <= 1'b0;
			end else if (!in_msg_q) begin
				older_q  <= TERM_ONE;
				newer_q  <= term_out;
				pos_q    <= POS_FIRST;
				in_msg_q <= 1'b1;
			end else begin
				older_q <= newer_q;
				newer_q <= term_out;
				pos_q   <= pos_q + POS_FIRST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (out_free) begin
			sum_valid_q <= take && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last_byte) begin
			checksum_q <= term_out;
		end
	end

	assign sum_valid = sum_valid_q;
	assign checksum  = checksum_q;

endmodule

@@ rtl/three_term_recurrence_checksum_unit.sv @@
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum_unit
// Checksum over a byte stream built from a three-term recurrence modulo 65535.
//
//   channel   handshake               payload
//   bytes     byte_valid/byte_stall   data_byte[7:0], last_byte
//   result    sum_valid/sum_stall     checksum[15:0]
//
// One byte is accepted every cycle; a stalled result holds only a final byte
// in the input register, and the bytes behind it wait. A byte is folded into
// the terms when the recurrence stage takes it from the input register, and
// the checksum of a message is registered when its last byte is taken. Reset
// clears both valid flags and returns the terms to the start of a message.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        sum_valid,
	input  logic        sum_stall,
	output logic [15:0] checksum
);
	import ttrc_pkg::*;

	byte_item_t item_s1;
	logic       take;

	ttrc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.take       (take),
		.item_s1    (item_s1)
	);

	ttrc_recur u_recur (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.take      (take),
		.sum_valid (sum_valid),
		.sum_stall (sum_stall),
		.checksum  (checksum)
	);

endmodule
